// ----- hw/rtl/lamp_sense_duty_monitor_core_assert.svh -----
// ----------------------------------------------------------------------------
// lamp sense duty monitor assertion macros
// clocked concurrent checks used by lsdm_out_buf
// ----------------------------------------------------------------------------
`ifndef LAMP_SENSE_DUTY_MONITOR_CORE_ASSERT_SVH
`define LAMP_SENSE_DUTY_MONITOR_CORE_ASSERT_SVH

// same-cycle implication, disabled while in reset
`define LSDM_ASSERT_NOW(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |-> (prop)) \
        else $error("lsdm check failed");

// next-cycle implication, disabled while in reset
`define LSDM_ASSERT_NEXT(label, clk, rst_n, cond, prop) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (cond) |=> (prop)) \
        else $error("lsdm check failed");

`endif

// ----- hw/rtl/lsdm_pkg.sv -----
// ----------------------------------------------------------------------------
// lsdm_pkg
// shared types, codes and status encoding of the lamp sense duty monitor
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package lsdm_pkg;

    localparam int NUM_CHANNELS      = 4;
    localparam int SIG_PER_CHAN      = 6;
    localparam int NUM_SIGNALS       = NUM_CHANNELS * SIG_PER_CHAN;
    localparam int COUNT_WIDTH_DEF   = 10;
    localparam int LIMIT_W           = 10;
    localparam int ADDR_W            = 4;
    localparam int VER_W             = 3;
    localparam int FRAME_W           = 11;
    localparam int WORD_W            = 16;
    localparam int FLAG_W            = 6;
    localparam int DMODE_W           = 3;
    localparam int CFG_IDX_W         = 3;

    // item kinds
    localparam logic [1:0] MODE_SAMPLE = 2'd0;
    localparam logic [1:0] MODE_WINDOW = 2'd1;
    localparam logic [1:0] MODE_CLEAR  = 2'd2;

    // register indexes
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_LIMIT = 3'd0;
    localparam logic [CFG_IDX_W-1:0] REG_CURR_LIMIT = 3'd1;
    localparam logic [CFG_IDX_W-1:0] REG_VOLT_THR   = 3'd2;
    localparam logic [CFG_IDX_W-1:0] REG_CURR_THR   = 3'd3;
    localparam logic [CFG_IDX_W-1:0] REG_BOARD_ADDR = 3'd4;
    localparam logic [CFG_IDX_W-1:0] REG_FW_VERSION = 3'd5;

    // display modes
    localparam logic [DMODE_W-1:0] DISP_DARK      = 3'd0;
    localparam logic [DMODE_W-1:0] DISP_RED       = 3'd1;
    localparam logic [DMODE_W-1:0] DISP_YELLOW    = 3'd2;
    localparam logic [DMODE_W-1:0] DISP_GREEN     = 3'd3;
    localparam logic [DMODE_W-1:0] DISP_RED_FL    = 3'd4;
    localparam logic [DMODE_W-1:0] DISP_YELLOW_FL = 3'd5;
    localparam logic [DMODE_W-1:0] DISP_GREEN_FL  = 3'd6;
    localparam logic [DMODE_W-1:0] DISP_YG        = 3'd7;

    // flag patterns
    localparam logic [FLAG_W-1:0] PAIR_RED    = 6'h30;
    localparam logic [FLAG_W-1:0] PAIR_YELLOW = 6'h0c;
    localparam logic [FLAG_W-1:0] PAIR_GREEN  = 6'h03;
    localparam logic [FLAG_W-1:0] PAT_YG      = 6'h0f;
    localparam logic [FLAG_W-1:0] RED_V       = 6'h10;
    localparam logic [FLAG_W-1:0] RED_C       = 6'h20;
    localparam logic [FLAG_W-1:0] YEL_V       = 6'h04;
    localparam logic [FLAG_W-1:0] YEL_C       = 6'h08;
    localparam logic [FLAG_W-1:0] GRN_V       = 6'h01;
    localparam logic [FLAG_W-1:0] GRN_C       = 6'h02;

    // fault codes
    localparam logic [FLAG_W-1:0] FAULT_NONE    = 6'h00;
    localparam logic [FLAG_W-1:0] FAULT_WRONG   = 6'h08;
    localparam logic [FLAG_W-1:0] FAULT_V_ONLY  = 6'h28;
    localparam logic [FLAG_W-1:0] FAULT_C_ONLY  = 6'h18;
    localparam logic [FLAG_W-1:0] FAULT_NEITHER = 6'h38;

    localparam logic [FRAME_W-1:0] FRAME_BASE = 11'h080;

    typedef struct packed {
        logic [LIMIT_W-1:0] volt_limit;
        logic [LIMIT_W-1:0] curr_limit;
        logic [LIMIT_W-1:0] volt_thr;
        logic [LIMIT_W-1:0] curr_thr;
    } lane_cfg_t;

    typedef struct packed {
        logic sample;
        logic clear;
    } lane_ctrl_t;

    typedef struct packed {
        logic [FRAME_W-1:0]                   frame_id;
        logic [NUM_CHANNELS-1:0][WORD_W-1:0]  words;
    } result_t;

    function automatic logic [FLAG_W-1:0] pair_code(
        input logic [FLAG_W-1:0] flags,
        input logic [FLAG_W-1:0] pair,
        input logic [FLAG_W-1:0] vbit,
        input logic [FLAG_W-1:0] cbit
    );
        logic [FLAG_W-1:0] m;
        logic [FLAG_W-1:0] code;
        m = flags & pair;
        priority if (flags == pair) code = FAULT_NONE;
        else if (m == pair)         code = FAULT_WRONG;
        else if (m == vbit)         code = FAULT_V_ONLY;
        else if (m == cbit)         code = FAULT_C_ONLY;
        else                        code = FAULT_NEITHER;
        return code;
    endfunction

    function automatic logic [WORD_W-1:0] encode(
        input logic [FLAG_W-1:0]  flags,
        input logic [DMODE_W-1:0] dmode,
        input logic               blink
    );
        logic [FLAG_W-1:0] code;
        logic [FLAG_W-1:0] dark_code;
        dark_code = (flags == '0) ? FAULT_NONE : FAULT_WRONG;
        unique case (dmode)
            DISP_DARK:      code = dark_code;
            DISP_YG:        code = (flags == PAT_YG) ? FAULT_NONE : FAULT_WRONG;
            DISP_RED:       code = pair_code(flags, PAIR_RED, RED_V, RED_C);
            DISP_YELLOW:    code = pair_code(flags, PAIR_YELLOW, YEL_V, YEL_C);
            DISP_GREEN:     code = pair_code(flags, PAIR_GREEN, GRN_V, GRN_C);
            DISP_RED_FL:    code = blink ? pair_code(flags, PAIR_RED, RED_V, RED_C)
                                         : dark_code;
            DISP_YELLOW_FL: code = blink ? pair_code(flags, PAIR_YELLOW, YEL_V, YEL_C)
                                         : dark_code;
            DISP_GREEN_FL:  code = blink ? pair_code(flags, PAIR_GREEN, GRN_V, GRN_C)
                                         : dark_code;
            default:        code = dark_code;
        endcase
        return {{(WORD_W-2*FLAG_W){1'b0}}, flags, {FLAG_W{1'b0}}}
             + {{(WORD_W-FLAG_W){1'b0}}, code}
             + {{(WORD_W-DMODE_W){1'b0}}, dmode};
    endfunction

endpackage

`default_nettype wire

// ----- hw/rtl/lsdm_lane.sv -----
// ----------------------------------------------------------------------------
// lsdm_lane
// one channel: six saturating presence counters and status word encoding
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lsdm_lane
    import lsdm_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                    clk,
    input  wire logic                    rst_n,
    input  wire lane_ctrl_t              ctrl,
    input  wire lane_cfg_t               cfg,
    input  wire logic [SIG_PER_CHAN-1:0] sense,
    input  wire logic [DMODE_W-1:0]      dmode,
    input  wire logic                    blink,
    output logic [WORD_W-1:0]            word
);

    localparam int CMP_W = (COUNT_WIDTH > LIMIT_W) ? COUNT_WIDTH : LIMIT_W;

    logic [COUNT_WIDTH-1:0] cnt_reg  [SIG_PER_CHAN];
    logic [COUNT_WIDTH-1:0] cnt_next [SIG_PER_CHAN];
    logic [FLAG_W-1:0]      flags;

    always_comb
    begin
        for (int k = 0; k < SIG_PER_CHAN; k++)
        begin
            logic [CMP_W-1:0] cnt_ext;
            logic [CMP_W-1:0] lim_ext;
            cnt_ext = CMP_W'(cnt_reg[k]);
            lim_ext = CMP_W'((k % 2 == 1) ? cfg.curr_limit : cfg.volt_limit);
            cnt_next[k] = cnt_reg[k];
            if (ctrl.clear)
                cnt_next[k] = '0;
            else if (ctrl.sample && !sense[k] && (cnt_ext < lim_ext) && !(&cnt_reg[k]))
                cnt_next[k] = cnt_reg[k] + 1'b1;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            for (int k = 0; k < SIG_PER_CHAN; k++)
                cnt_reg[k] <= '0;
        end
        else
        begin
            for (int k = 0; k < SIG_PER_CHAN; k++)
                cnt_reg[k] <= cnt_next[k];
        end
    end

    // red, yellow, green from msb down; current above voltage
    always_comb
    begin
        for (int p = 0; p < SIG_PER_CHAN / 2; p++)
        begin
            flags[FLAG_W-1-2*p] = CMP_W'(cnt_reg[2*p+1]) > CMP_W'(cfg.curr_thr);
            flags[FLAG_W-2-2*p] = CMP_W'(cnt_reg[2*p])   > CMP_W'(cfg.volt_thr);
        end
    end

    assign word = encode(flags, dmode, blink);

endmodule

`default_nettype wire

// ----- hw/rtl/lsdm_out_buf.sv -----
// ----------------------------------------------------------------------------
// lsdm_out_buf
// merges the lane words into one result and holds it in a two-entry buffer
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

`include "lamp_sense_duty_monitor_core_assert.svh"

module lsdm_out_buf
    import lsdm_pkg::*;
(
    input  wire logic                                clk,
    input  wire logic                                rst_n,
    input  wire logic                                push,
    input  wire logic [FRAME_W-1:0]                  push_frame,
    input  wire logic [NUM_CHANNELS-1:0][WORD_W-1:0] push_words,
    output logic                                     full,
    output logic                                     out_valid,
    input  wire logic                                out_stall,
    output result_t                                  out_data
);

    result_t main_reg;
    result_t skid_reg;
    result_t push_data;
    logic    main_v_reg;
    logic    skid_v_reg;
    logic    pop;

    assign push_data = '{frame_id: push_frame, words: push_words};
    assign pop       = main_v_reg && !out_stall;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            main_v_reg <= 1'b0;
            skid_v_reg <= 1'b0;
        end
        else if (!main_v_reg || pop)
        begin
            if (skid_v_reg)
            begin
                main_v_reg <= 1'b1;
                skid_v_reg <= push;
            end
            else
            begin
                main_v_reg <= push;
            end
        end
        else if (push)
        begin
            skid_v_reg <= 1'b1;
        end
    end

    always_ff @(posedge clk)
    begin
        if (!main_v_reg || pop)
        begin
            if (skid_v_reg)
            begin
                main_reg <= skid_reg;
                skid_reg <= push_data;
            end
            else
            begin
                main_reg <= push_data;
            end
        end
        else if (push)
        begin
            skid_reg <= push_data;
        end
    end

    assign full      = skid_v_reg;
    assign out_valid = main_v_reg;
    assign out_data  = main_reg;

    `LSDM_ASSERT_NOW(a_skid_behind_main, clk, rst_n, skid_v_reg, main_v_reg)
    `LSDM_ASSERT_NOW(a_no_push_when_full, clk, rst_n, skid_v_reg, !push)
    `LSDM_ASSERT_NEXT(a_stalled_push_to_skid, clk, rst_n, push && main_v_reg && !pop, skid_v_reg)
    `LSDM_ASSERT_NEXT(a_skid_kept, clk, rst_n, skid_v_reg && !pop, skid_v_reg && main_v_reg)

endmodule

`default_nettype wire

// ----- hw/rtl/lamp_sense_duty_monitor_core.sv -----
// ----------------------------------------------------------------------------
// lamp_sense_duty_monitor_core
// lamp sense presence counting, window evaluation and status frame build
// ----------------------------------------------------------------------------
//
//   channel   handshake              payload
//   -------   --------------------   ------------------------------------------
//   input     in_valid / in_stall    mode, sense_bits, channel_mode_0..3,
//                                    blink_phase
//   output    out_valid / out_stall  frame_id, status_word_0..3
//   config    cfg_we                 cfg_index, cfg_wdata
//
// one input transaction per cycle while in_stall is low; a window-end result
// is registered into the output buffer when its transaction is accepted
// the counters of all lanes update in the same cycle as the accept
// the two-entry output buffer sets the rate: in_stall rises only while
// both entries hold results that the output side has not taken
// reset clears the counters and loads the register defaults at once
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module lamp_sense_duty_monitor_core
    import lsdm_pkg::*;
#(
    parameter int COUNT_WIDTH = COUNT_WIDTH_DEF
) (
    input  wire logic                   clk,
    input  wire logic                   rst_n,
    // configuration write port
    input  wire logic                   cfg_we,
    input  wire logic [CFG_IDX_W-1:0]   cfg_index,
    input  wire logic [LIMIT_W-1:0]     cfg_wdata,
    // input channel
    input  wire logic                   in_valid,
    output logic                        in_stall,
    input  wire logic [1:0]             mode,
    input  wire logic [NUM_SIGNALS-1:0] sense_bits,
    input  wire logic [DMODE_W-1:0]     channel_mode_0,
    input  wire logic [DMODE_W-1:0]     channel_mode_1,
    input  wire logic [DMODE_W-1:0]     channel_mode_2,
    input  wire logic [DMODE_W-1:0]     channel_mode_3,
    input  wire logic                   blink_phase,
    // output channel
    output logic                        out_valid,
    input  wire logic                   out_stall,
    output logic [FRAME_W-1:0]          frame_id,
    output logic [WORD_W-1:0]           status_word_0,
    output logic [WORD_W-1:0]           status_word_1,
    output logic [WORD_W-1:0]           status_word_2,
    output logic [WORD_W-1:0]           status_word_3
);

    // configuration registers
    lane_cfg_t          cfg_reg;
    logic [ADDR_W-1:0]  board_addr_reg;
    logic [VER_W-1:0]   fw_version_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg.volt_limit <= LIMIT_W'(400);
            cfg_reg.curr_limit <= LIMIT_W'(400);
            cfg_reg.volt_thr   <= LIMIT_W'(200);
            cfg_reg.curr_thr   <= LIMIT_W'(200);
            board_addr_reg     <= '0;
            fw_version_reg     <= '0;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_VOLT_LIMIT: cfg_reg.volt_limit <= cfg_wdata;
                REG_CURR_LIMIT: cfg_reg.curr_limit <= cfg_wdata;
                REG_VOLT_THR:   cfg_reg.volt_thr   <= cfg_wdata;
                REG_CURR_THR:   cfg_reg.curr_thr   <= cfg_wdata;
                REG_BOARD_ADDR: board_addr_reg     <= cfg_wdata[ADDR_W-1:0];
                REG_FW_VERSION: fw_version_reg     <= cfg_wdata[VER_W-1:0];
                default:        ;  // writes beyond the register list are dropped
            endcase
        end
    end

    // input accept and item decode
    logic       in_accept;
    logic       buf_full;
    lane_ctrl_t lane_ctrl;
    logic       win_push;

    assign in_stall       = buf_full;
    assign in_accept      = in_valid && !in_stall;
    assign lane_ctrl.sample = in_accept && (mode == MODE_SAMPLE);
    assign lane_ctrl.clear  = in_accept && (mode == MODE_CLEAR);
    assign win_push         = in_accept && (mode == MODE_WINDOW);

    // per-channel display modes in lane order
    logic [DMODE_W-1:0] chan_mode [NUM_CHANNELS];

    assign chan_mode[0] = channel_mode_0;
    assign chan_mode[1] = channel_mode_1;
    assign chan_mode[2] = channel_mode_2;
    assign chan_mode[3] = channel_mode_3;

    // one lane per channel, each owning its six sense counters
    logic [NUM_CHANNELS-1:0][WORD_W-1:0] lane_words;

    for (genvar c = 0; c < NUM_CHANNELS; c++)
    begin : g_lane
        lsdm_lane #(
            .COUNT_WIDTH (COUNT_WIDTH)
        ) u_lane (
            .clk   (clk),
            .rst_n (rst_n),
            .ctrl  (lane_ctrl),
            .cfg   (cfg_reg),
            .sense (sense_bits[c*SIG_PER_CHAN +: SIG_PER_CHAN]),
            .dmode (chan_mode[c]),
            .blink (blink_phase),
            .word  (lane_words[c])
        );
    end

    // frame id: address from bit three up, fixed base, version in the low bits
    logic [FRAME_W-1:0] frame_next;

    assign frame_next = {{(FRAME_W-ADDR_W-3){1'b0}}, board_addr_reg, 3'b000}
                      + FRAME_BASE
                      + {{(FRAME_W-VER_W){1'b0}}, fw_version_reg};

    // merge lane words into the result and buffer it
    result_t res;

    lsdm_out_buf u_out_buf (
        .clk        (clk),
        .rst_n      (rst_n),
        .push       (win_push),
        .push_frame (frame_next),
        .push_words (lane_words),
        .full       (buf_full),
        .out_valid  (out_valid),
        .out_stall  (out_stall),
        .out_data   (res)
    );

    assign frame_id      = res.frame_id;
    assign status_word_0 = res.words[0];
    assign status_word_1 = res.words[1];
    assign status_word_2 = res.words[2];
    assign status_word_3 = res.words[3];

endmodule

`default_nettype wire

// ----- tb/tb_top.sv -----
// ----------------------------------------------------------------------------
// tb_top
// self-checking bench for the lamp sense duty monitor: sample, window-end and
// clear transactions under random idling and output hold-off, with every
// status frame checked against an independent prediction of the counters
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

import lsdm_pkg::*;

// one input transaction as the bench sees it
typedef struct packed {
    logic [1:0]                           kind;
    logic [NUM_SIGNALS-1:0]               sense;
    logic [NUM_CHANNELS-1:0][DMODE_W-1:0] dmode;
    logic                                 blink;
} sense_item_t;

// full register set, written as one block between phases
typedef struct packed {
    logic [LIMIT_W-1:0] volt_limit;
    logic [LIMIT_W-1:0] curr_limit;
    logic [LIMIT_W-1:0] volt_thr;
    logic [LIMIT_W-1:0] curr_thr;
    logic [ADDR_W-1:0]  board_addr;
    logic [VER_W-1:0]   fw_version;
} monitor_setup_t;

class lamp_frame_scoreboard;
    localparam int unsigned COUNT_CEIL    = (1 << COUNT_WIDTH_DEF) - 1;
    localparam int unsigned RST_LIMIT     = 400;
    localparam int unsigned RST_THRESHOLD = 200;

    int unsigned        presence[NUM_SIGNALS];
    logic [LIMIT_W-1:0] volt_limit;
    logic [LIMIT_W-1:0] curr_limit;
    logic [LIMIT_W-1:0] volt_thr;
    logic [LIMIT_W-1:0] curr_thr;
    logic [ADDR_W-1:0]  board_addr;
    logic [VER_W-1:0]   fw_version;
    result_t            expected_frames[$];
    int                 failures;

    function new();
        volt_limit = LIMIT_W'(RST_LIMIT);
        curr_limit = LIMIT_W'(RST_LIMIT);
        volt_thr   = LIMIT_W'(RST_THRESHOLD);
        curr_thr   = LIMIT_W'(RST_THRESHOLD);
        board_addr = '0;
        fw_version = '0;
        foreach (presence[i]) presence[i] = 0;
        failures = 0;
    endfunction

    function void set_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
        case (idx)
            REG_VOLT_LIMIT: volt_limit = val;
            REG_CURR_LIMIT: curr_limit = val;
            REG_VOLT_THR:   volt_thr   = val;
            REG_CURR_THR:   curr_thr   = val;
            REG_BOARD_ADDR: board_addr = val[ADDR_W-1:0];
            REG_FW_VERSION: fw_version = val[VER_W-1:0];
            default: ;
        endcase
    endfunction

    function int pending();
        return expected_frames.size();
    endfunction

    // lamp 0 red, 1 yellow, 2 green; current flag sits above voltage flag
    function logic [FLAG_W-1:0] lamp_fault(input logic [FLAG_W-1:0] flags, input int lamp);
        logic [FLAG_W-1:0] both;
        logic              cur;
        logic              volt;
        both = PAIR_RED >> (2 * lamp);
        cur  = flags[FLAG_W - 1 - 2 * lamp];
        volt = flags[FLAG_W - 2 - 2 * lamp];
        if (flags == both)
            return FAULT_NONE;
        if (cur && volt)
            return FAULT_WRONG;
        if (volt)
            return FAULT_V_ONLY;
        if (cur)
            return FAULT_C_ONLY;
        return FAULT_NEITHER;
    endfunction

    function logic [WORD_W-1:0] status_word(input logic [FLAG_W-1:0] flags,
                                            input logic [DMODE_W-1:0] dm,
                                            input logic blink);
        logic [FLAG_W-1:0] code;
        logic [FLAG_W-1:0] dark;
        dark = (flags == '0) ? FAULT_NONE : FAULT_WRONG;
        case (dm)
            DISP_DARK:
                code = dark;
            DISP_YG:
                code = (flags == PAT_YG) ? FAULT_NONE : FAULT_WRONG;
            DISP_RED, DISP_YELLOW, DISP_GREEN:
                code = lamp_fault(flags, int'(dm) - int'(DISP_RED));
            default:
                code = blink ? lamp_fault(flags, int'(dm) - int'(DISP_RED_FL)) : dark;
        endcase
        return (WORD_W'(flags) << FLAG_W) + WORD_W'(code) + WORD_W'(dm);
    endfunction

    function void note_item(input sense_item_t it);
        result_t           frame;
        logic [FLAG_W-1:0] flags;
        int unsigned       cap;
        int                sig;
        case (it.kind)
            MODE_SAMPLE:
                for (int i = 0; i < NUM_SIGNALS; i++) begin
                    cap = (i % 2 == 1) ? curr_limit : volt_limit;
                    if (!it.sense[i] && presence[i] < cap && presence[i] < COUNT_CEIL)
                        presence[i]++;
                end
            MODE_CLEAR:
                foreach (presence[i]) presence[i] = 0;
            MODE_WINDOW:
            begin
                frame.frame_id = (FRAME_W'(board_addr) << VER_W) + FRAME_BASE
                               + FRAME_W'(fw_version);
                for (int c = 0; c < NUM_CHANNELS; c++) begin
                    flags = '0;
                    for (int l = 0; l < 3; l++) begin
                        sig = c * SIG_PER_CHAN + 2 * l;
                        flags[FLAG_W - 1 - 2 * l] = presence[sig + 1] > curr_thr;
                        flags[FLAG_W - 2 - 2 * l] = presence[sig] > volt_thr;
                    end
                    frame.words[c] = status_word(flags, it.dmode[c], it.blink);
                end
                expected_frames.push_back(frame);
            end
            default: ;
        endcase
    endfunction

    function void check_frame(input result_t got);
        result_t want;
        if (expected_frames.size() == 0) begin
            $error("status frame with none expected, frame_id %0h", got.frame_id);
            failures++;
            return;
        end
        want = expected_frames.pop_front();
        if (got.frame_id !== want.frame_id) begin
            $error("frame_id expected %0h actual %0h", want.frame_id, got.frame_id);
            failures++;
        end
        for (int c = 0; c < NUM_CHANNELS; c++)
            if (got.words[c] !== want.words[c]) begin
                $error("status_word_%0d expected %04h actual %04h",
                       c, want.words[c], got.words[c]);
                failures++;
            end
    endfunction
endclass

module tb_top;

    localparam int MODES_W      = NUM_CHANNELS * DMODE_W;
    localparam int CYCLE_LIMIT  = 200000;
    localparam int DRAIN_CYCLES = 4;
    localparam int END_CYCLES   = 8;
    localparam int HOLD_CYCLES  = 120;
    localparam int RANDOM_ITEMS = 850;
    localparam int SAT_SAMPLES  = 1030;
    localparam int MAX_SAMPLES  = 40;

    // mode value 3 has no function in the block and is simply dropped
    localparam logic [1:0] MODE_SPARE = 2'd3;

    // present signals per channel for the directed case: ch0 red pair,
    // ch1 red voltage only, ch2 red current only, ch3 yellow and green
    localparam logic [NUM_SIGNALS-1:0] PRESENT_MIX = {6'b111100, 6'b000010,
                                                      6'b000001, 6'b000011};

    logic                   clk = 1'b0;
    logic                   rst_n = 1'b0;
    logic                   cfg_we = 1'b0;
    logic [CFG_IDX_W-1:0]   cfg_index = '0;
    logic [LIMIT_W-1:0]     cfg_wdata = '0;
    logic                   in_valid = 1'b0;
    logic                   in_stall;
    logic [1:0]             mode = MODE_SAMPLE;
    logic [NUM_SIGNALS-1:0] sense_bits = '1;
    logic [DMODE_W-1:0]     channel_mode_0 = DISP_DARK;
    logic [DMODE_W-1:0]     channel_mode_1 = DISP_DARK;
    logic [DMODE_W-1:0]     channel_mode_2 = DISP_DARK;
    logic [DMODE_W-1:0]     channel_mode_3 = DISP_DARK;
    logic                   blink_phase = 1'b0;
    logic                   out_valid;
    logic                   out_stall = 1'b0;
    logic [FRAME_W-1:0]     frame_id;
    logic [WORD_W-1:0]      status_word_0;
    logic [WORD_W-1:0]      status_word_1;
    logic [WORD_W-1:0]      status_word_2;
    logic [WORD_W-1:0]      status_word_3;

    lamp_frame_scoreboard board;

    // steady: no random idling on either side
    // hold_req: asks the receiver for one long hold-off
    bit steady = 1'b0;
    bit hold_req = 1'b0;
    int hold_left = 0;
    int items_sent = 0;
    int cycles = 0;

    lamp_sense_duty_monitor_core dut (
        .clk            (clk),
        .rst_n          (rst_n),
        .cfg_we         (cfg_we),
        .cfg_index      (cfg_index),
        .cfg_wdata      (cfg_wdata),
        .in_valid       (in_valid),
        .in_stall       (in_stall),
        .mode           (mode),
        .sense_bits     (sense_bits),
        .channel_mode_0 (channel_mode_0),
        .channel_mode_1 (channel_mode_1),
        .channel_mode_2 (channel_mode_2),
        .channel_mode_3 (channel_mode_3),
        .blink_phase    (blink_phase),
        .out_valid      (out_valid),
        .out_stall      (out_stall),
        .frame_id       (frame_id),
        .status_word_0  (status_word_0),
        .status_word_1  (status_word_1),
        .status_word_2  (status_word_2),
        .status_word_3  (status_word_3)
    );

    always #5 clk = ~clk;

    // watchdog on the whole run
    always @(posedge clk) begin
        cycles++;
        if (cycles >= CYCLE_LIMIT) begin
            $display("SCOREBOARD MISMATCH");
            $finish;
        end
    end

    // receiver: random stalls, or one long hold-off on request so that the
    // output buffer fills and the block pushes back on its input
    always @(posedge clk) begin
        if (hold_left > 0) begin
            hold_left--;
            out_stall <= 1'b1;
        end
        else if (hold_req) begin
            hold_req = 1'b0;
            hold_left = HOLD_CYCLES - 1;
            out_stall <= 1'b1;
        end
        else begin
            out_stall <= !steady && ($urandom_range(0, 99) < 12);
        end
    end

    // output monitor: a transaction completes when valid is high and stall low
    always @(posedge clk) begin : watch_output
        result_t got;
        got.frame_id = frame_id;
        got.words[0] = status_word_0;
        got.words[1] = status_word_1;
        got.words[2] = status_word_2;
        got.words[3] = status_word_3;
        if (rst_n && out_valid && !out_stall)
            board.check_frame(got);
    end

    function automatic sense_item_t pack_item(input logic [1:0] kind,
                                              input logic [NUM_SIGNALS-1:0] sense,
                                              input logic [MODES_W-1:0] dmodes,
                                              input logic blink);
        sense_item_t it;
        it.kind  = kind;
        it.sense = sense;
        it.dmode = dmodes;
        it.blink = blink;
        return it;
    endfunction

    function automatic logic [MODES_W-1:0] rand_modes();
        return MODES_W'($urandom);
    endfunction

    function automatic logic rand_bit();
        return 1'($urandom_range(0, 1));
    endfunction

    // signals a healthy channel shows for a display mode, bit k is signal k
    function automatic logic [SIG_PER_CHAN-1:0] lamps_lit(input logic [DMODE_W-1:0] dm);
        case (dm)
            DISP_RED, DISP_RED_FL:       return 6'b000011;
            DISP_YELLOW, DISP_YELLOW_FL: return 6'b001100;
            DISP_GREEN, DISP_GREEN_FL:   return 6'b110000;
            DISP_YG:                     return 6'b111100;
            default:                     return 6'b000000;
        endcase
    endfunction

    // present one transaction, hold it until accepted, then log it
    task automatic offer(input sense_item_t it);
        if (!steady && $urandom_range(0, 99) < 12) begin
            in_valid <= 1'b0;
            repeat ($urandom_range(1, 2)) @(posedge clk);
        end
        in_valid       <= 1'b1;
        mode           <= it.kind;
        sense_bits     <= it.sense;
        channel_mode_0 <= it.dmode[0];
        channel_mode_1 <= it.dmode[1];
        channel_mode_2 <= it.dmode[2];
        channel_mode_3 <= it.dmode[3];
        blink_phase    <= it.blink;
        do
            @(posedge clk);
        while (in_stall);
        board.note_item(it);
        if (it.kind != MODE_SPARE)
            items_sent++;
    endtask

    // stop sending and wait until every frame is out and the block is quiet
    task automatic drain_and_idle();
        in_valid <= 1'b0;
        while (board.pending() != 0)
            @(posedge clk);
        repeat (DRAIN_CYCLES) @(posedge clk);
    endtask

    task automatic put_reg(input logic [CFG_IDX_W-1:0] idx, input logic [LIMIT_W-1:0] val);
        cfg_we    <= 1'b1;
        cfg_index <= idx;
        cfg_wdata <= val;
        @(posedge clk);
        board.set_reg(idx, val);
    endtask

    task automatic write_setup(input monitor_setup_t s);
        put_reg(REG_VOLT_LIMIT, s.volt_limit);
        put_reg(REG_CURR_LIMIT, s.curr_limit);
        put_reg(REG_VOLT_THR, s.volt_thr);
        put_reg(REG_CURR_THR, s.curr_thr);
        put_reg(REG_BOARD_ADDR, LIMIT_W'(s.board_addr));
        put_reg(REG_FW_VERSION, LIMIT_W'(s.fw_version));
        cfg_we <= 1'b0;
    endtask

    // one measurement window: optional clear, samples that mostly follow the
    // lamps each channel should show, then the window-end transaction
    task automatic run_window_sequence();
        logic [MODES_W-1:0]               dms;
        logic [NUM_CHANNELS-1:0][DMODE_W-1:0] dm_each;
        logic [NUM_SIGNALS-1:0]           wanted;
        logic [NUM_SIGNALS-1:0]           s;
        int                               n;
        dms = rand_modes();
        dm_each = dms;
        for (int c = 0; c < NUM_CHANNELS; c++)
            wanted[c * SIG_PER_CHAN +: SIG_PER_CHAN] =
                ($urandom_range(0, 9) < 3) ? SIG_PER_CHAN'($urandom) : lamps_lit(dm_each[c]);
        if ($urandom_range(0, 9) < 7)
            offer(pack_item(MODE_CLEAR, NUM_SIGNALS'($urandom), rand_modes(), rand_bit()));
        n = $urandom_range(0, MAX_SAMPLES);
        repeat (n) begin
            for (int b = 0; b < NUM_SIGNALS; b++)
                s[b] = wanted[b] ? ($urandom_range(0, 9) == 0) : ($urandom_range(0, 9) != 0);
            offer(pack_item(MODE_SAMPLE, s, rand_modes(), rand_bit()));
        end
        offer(pack_item(MODE_WINDOW, NUM_SIGNALS'($urandom), dms, rand_bit()));
    endtask

    initial begin
        monitor_setup_t         setup;
        logic [NUM_SIGNALS-1:0] sat_sense;
        int                     phase;
        int                     target;

        board = new();
        repeat (3) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        // ---- directed: small limits and thresholds so flags move quickly
        setup = '{volt_limit: 10'd3, curr_limit: 10'd2, volt_thr: 10'd1, curr_thr: 10'd0,
                  board_addr: 4'd15, fw_version: 3'd7};
        write_setup(setup);
        // empty counters: dark matches, pair modes report neither lamp
        offer(pack_item(MODE_WINDOW, '1, {DISP_GREEN, DISP_YELLOW, DISP_RED, DISP_DARK}, 1'b0));
        offer(pack_item(MODE_WINDOW, '0,
                        {DISP_YG, DISP_GREEN_FL, DISP_YELLOW_FL, DISP_RED_FL}, 1'b1));
        repeat (2) offer(pack_item(MODE_SAMPLE, ~PRESENT_MIX, '1, 1'b0));
        // match, voltage only, current only, yellow plus green
        offer(pack_item(MODE_WINDOW, '0, {DISP_YG, DISP_RED, DISP_RED, DISP_RED}, 1'b0));
        // flashing off phase with lamps lit, wrong lamp, dark with lamps, green pair
        // inside a wider pattern
        offer(pack_item(MODE_WINDOW, '0,
                        {DISP_GREEN, DISP_DARK, DISP_YELLOW, DISP_RED_FL}, 1'b0));
        offer(pack_item(MODE_WINDOW, '0,
                        {DISP_YG, DISP_GREEN_FL, DISP_YELLOW_FL, DISP_RED_FL}, 1'b1));
        // counters run into their limits
        repeat (3) offer(pack_item(MODE_SAMPLE, ~PRESENT_MIX, '0, 1'b1));
        offer(pack_item(MODE_SPARE, '0, '1, 1'b1));
        offer(pack_item(MODE_WINDOW, '1, {DISP_DARK, DISP_DARK, DISP_DARK, DISP_DARK}, 1'b1));
        offer(pack_item(MODE_SAMPLE, '1, '1, 1'b0));
        offer(pack_item(MODE_CLEAR, '0, '0, 1'b0));
        offer(pack_item(MODE_WINDOW, '1, {DISP_YG, DISP_YG, DISP_GREEN, DISP_RED}, 1'b0));
        repeat (2) offer(pack_item(MODE_SAMPLE, '0, '0, 1'b0));
        offer(pack_item(MODE_WINDOW, '0,
                        {DISP_GREEN_FL, DISP_YELLOW_FL, DISP_RED_FL, DISP_YG}, 1'b1));
        offer(pack_item(MODE_WINDOW, '0,
                        {DISP_GREEN_FL, DISP_YELLOW_FL, DISP_RED_FL, DISP_YG}, 1'b0));

        // ---- extremes: zero limits and thresholds, counters can never rise
        drain_and_idle();
        setup = '{volt_limit: 10'd0, curr_limit: 10'd0, volt_thr: 10'd0, curr_thr: 10'd0,
                  board_addr: 4'd0, fw_version: 3'd7};
        write_setup(setup);
        repeat (3) run_window_sequence();

        // ---- full-range limits: counters saturate at their all-ones value
        drain_and_idle();
        setup = '{volt_limit: 10'd1023, curr_limit: 10'd1023, volt_thr: 10'd1022,
                  curr_thr: 10'd1022, board_addr: 4'd15, fw_version: 3'd0};
        write_setup(setup);
        sat_sense = NUM_SIGNALS'($urandom);
        offer(pack_item(MODE_CLEAR, '1, '0, 1'b0));
        repeat (SAT_SAMPLES) offer(pack_item(MODE_SAMPLE, sat_sense, rand_modes(), rand_bit()));
        repeat (2) offer(pack_item(MODE_WINDOW, '0, rand_modes(), rand_bit()));

        // ---- limits lowered under the saturated counters, no clear in between
        drain_and_idle();
        setup.volt_limit = 10'd10;
        setup.curr_limit = 10'd10;
        setup.board_addr = 4'd5;
        setup.fw_version = 3'd3;
        write_setup(setup);
        repeat (20) offer(pack_item(MODE_SAMPLE, NUM_SIGNALS'($urandom), rand_modes(), 1'b0));
        offer(pack_item(MODE_WINDOW, '0, rand_modes(), rand_bit()));

        // ---- top thresholds: nothing can flag
        drain_and_idle();
        setup = '{volt_limit: 10'd1023, curr_limit: 10'd1023, volt_thr: 10'd1023,
                  curr_thr: 10'd1023, board_addr: 4'd10, fw_version: 3'd5};
        write_setup(setup);
        repeat (2) offer(pack_item(MODE_SAMPLE, '0, rand_modes(), 1'b1));
        offer(pack_item(MODE_WINDOW, '0, rand_modes(), 1'b1));
        run_window_sequence();

        // ---- random phases, each with its own register setting
        phase = 0;
        target = items_sent + RANDOM_ITEMS;
        while (items_sent < target) begin
            drain_and_idle();
            setup.volt_limit = ($urandom_range(0, 9) == 0) ? LIMIT_W'($urandom_range(0, 1023))
                                                           : LIMIT_W'($urandom_range(0, 48));
            setup.curr_limit = ($urandom_range(0, 9) == 0) ? LIMIT_W'($urandom_range(0, 1023))
                                                           : LIMIT_W'($urandom_range(0, 48));
            setup.volt_thr   = LIMIT_W'($urandom_range(0, 24));
            setup.curr_thr   = LIMIT_W'($urandom_range(0, 24));
            setup.board_addr = ADDR_W'($urandom_range(0, 15));
            setup.fw_version = VER_W'($urandom_range(0, 7));
            write_setup(setup);
            // a couple of phases run with no idling at all
            steady = (phase == 3 || phase == 4);
            if (phase == 2) begin
                // long receiver hold-off while window ends keep coming
                hold_req = 1'b1;
                steady = 1'b1;
                repeat (16) offer(pack_item(MODE_WINDOW, NUM_SIGNALS'($urandom),
                                            rand_modes(), rand_bit()));
                steady = 1'b0;
            end
            repeat (8) begin
                if ($urandom_range(0, 5) == 0)
                    repeat ($urandom_range(1, 3))
                        offer(pack_item(2'($urandom_range(0, 3)), NUM_SIGNALS'($urandom),
                                        rand_modes(), rand_bit()));
                run_window_sequence();
            end
            steady = 1'b0;
            phase++;
        end

        drain_and_idle();
        repeat (END_CYCLES) @(posedge clk);
        if (board.failures == 0 && board.pending() == 0)
            $display("SCOREBOARD CLEAN");
        else
            $display("SCOREBOARD MISMATCH");
        $finish;
    end

endmodule
